// ===== src/chebyshev_coefficient_generator_unit_defines.svh =====
// Assertion macros shared by the Chebyshev coefficient generator RTL.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef CHEBYSHEV_COEFFICIENT_GENERATOR_UNIT_DEFINES_SVH
`define CHEBYSHEV_COEFFICIENT_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CCG_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CCG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ccg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the Chebyshev coefficient generator.
// Used by the sequencer, the datapath and the top level; depends on nothing.
package ccg_pkg;

  localparam int DEG_W      = 8;
  localparam int COEF_W     = 64;
  localparam int POW_W      = 6;
  localparam int OUT_TDATA_W = 72;
  localparam int UPC_W      = 4;

  // Datapath operation selected by the current control word.
  typedef enum logic [3:0] {
    OP_NONE      = 4'd0,
    OP_TAKE      = 4'd1,
    OP_INIT_A    = 4'd2,
    OP_INIT_B0   = 4'd3,
    OP_INIT_B1   = 4'd4,
    OP_PRIME_ROW = 4'd5,
    OP_STEP      = 4'd6,
    OP_SWAP      = 4'd7,
    OP_PRIME_OUT = 4'd8,
    OP_SCAN      = 4'd9,
    OP_FLUSH     = 4'd10,
    OP_ERR       = 4'd11
  } ccg_op_t;

  // Jump condition of a control word; the jump is taken when it is true.
  typedef enum logic [3:0] {
    C_NEVER     = 4'd0,
    C_ALWAYS    = 4'd1,
    C_NO_INPUT  = 4'd2,
    C_BAD_DEG   = 4'd3,
    C_DEG_LT2   = 4'd4,
    C_ROW_BUSY  = 4'd5,
    C_MORE_ROWS = 4'd6,
    C_SCAN_BUSY = 4'd7,
    C_OUT_FULL  = 4'd8
  } ccg_cond_t;

  typedef struct packed {
    ccg_op_t          op;
    ccg_cond_t        cond;
    logic [UPC_W-1:0] target;
    logic             eop;     // fall through to the wait step
  } ccg_ctl_t;

  typedef struct packed {
    logic no_input;
    logic bad_deg;
    logic deg_lt2;
    logic row_busy;
    logic more_rows;
    logic scan_busy;
    logic out_full;
  } ccg_stat_t;

  typedef struct packed {
    logic              valid;
    logic [COEF_W-1:0] coef;
    logic [POW_W-1:0]  power;
    logic              last;
    logic              error;
  } ccg_push_t;

endpackage

// ===== src/ccg_sequencer.sv =====
`timescale 1ns / 1ps
// Microprogram sequencer: step counter, control ROM and jump logic.
// Depends on ccg_pkg for the control word and status types.
module ccg_sequencer import ccg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  ccg_stat_t stat_i,
  output ccg_ctl_t  ctl_o
);

  localparam logic [UPC_W-1:0] P_WAIT     = 4'd0;
  localparam logic [UPC_W-1:0] P_CHECK    = 4'd1;
  localparam logic [UPC_W-1:0] P_INIT_A   = 4'd2;
  localparam logic [UPC_W-1:0] P_INIT_B0  = 4'd3;
  localparam logic [UPC_W-1:0] P_INIT_B1  = 4'd4;
  localparam logic [UPC_W-1:0] P_ROW      = 4'd5;
  localparam logic [UPC_W-1:0] P_LOOP     = 4'd6;
  localparam logic [UPC_W-1:0] P_SWAP     = 4'd7;
  localparam logic [UPC_W-1:0] P_OUT      = 4'd8;
  localparam logic [UPC_W-1:0] P_SCAN     = 4'd9;
  localparam logic [UPC_W-1:0] P_FLUSH    = 4'd10;
  localparam logic [UPC_W-1:0] P_ERR      = 4'd11;

  function automatic ccg_ctl_t ucode(input logic [UPC_W-1:0] a);
    ccg_ctl_t w;
    w = '{op: OP_NONE, cond: C_ALWAYS, target: P_WAIT, eop: 1'b1};
    unique case (a)
      P_WAIT:    w = '{op: OP_TAKE,      cond: C_NO_INPUT,  target: P_WAIT,  eop: 1'b0};
      P_CHECK:   w = '{op: OP_NONE,      cond: C_BAD_DEG,   target: P_ERR,   eop: 1'b0};
      P_INIT_A:  w = '{op: OP_INIT_A,    cond: C_NEVER,     target: P_WAIT,  eop: 1'b0};
      P_INIT_B0: w = '{op: OP_INIT_B0,   cond: C_NEVER,     target: P_WAIT,  eop: 1'b0};
      P_INIT_B1: w = '{op: OP_INIT_B1,   cond: C_DEG_LT2,   target: P_OUT,   eop: 1'b0};
      P_ROW:     w = '{op: OP_PRIME_ROW, cond: C_NEVER,     target: P_WAIT,  eop: 1'b0};
      P_LOOP:    w = '{op: OP_STEP,      cond: C_ROW_BUSY,  target: P_LOOP,  eop: 1'b0};
      P_SWAP:    w = '{op: OP_SWAP,      cond: C_MORE_ROWS, target: P_ROW,   eop: 1'b0};
      P_OUT:     w = '{op: OP_PRIME_OUT, cond: C_NEVER,     target: P_WAIT,  eop: 1'b0};
      P_SCAN:    w = '{op: OP_SCAN,      cond: C_SCAN_BUSY, target: P_SCAN,  eop: 1'b0};
      P_FLUSH:   w = '{op: OP_FLUSH,     cond: C_OUT_FULL,  target: P_FLUSH, eop: 1'b1};
      P_ERR:     w = '{op: OP_ERR,       cond: C_OUT_FULL,  target: P_ERR,   eop: 1'b1};
      default:   w = '{op: OP_NONE,      cond: C_ALWAYS,    target: P_WAIT,  eop: 1'b1};
    endcase
    return w;
  endfunction

  logic [UPC_W-1:0] upc_r;
  logic [UPC_W-1:0] upc_nxt;
  ccg_ctl_t         ctl;
  logic             jump;

  assign ctl   = ucode(upc_r);
  assign ctl_o = ctl;

  always_comb begin
    unique case (ctl.cond)
      C_NEVER:     jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_NO_INPUT:  jump = stat_i.no_input;
      C_BAD_DEG:   jump = stat_i.bad_deg;
      C_DEG_LT2:   jump = stat_i.deg_lt2;
      C_ROW_BUSY:  jump = stat_i.row_busy;
      C_MORE_ROWS: jump = stat_i.more_rows;
      C_SCAN_BUSY: jump = stat_i.scan_busy;
      C_OUT_FULL:  jump = stat_i.out_full;
      default:     jump = 1'b1;
    endcase
    if (jump) begin
      upc_nxt = ctl.target;
    end else if (ctl.eop) begin
      upc_nxt = P_WAIT;
    end else begin
      upc_nxt = upc_r + UPC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= P_WAIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// ===== src/ccg_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: two coefficient row memories, the recurrence adder and the
// output scanner with its one-entry look-ahead. Depends on ccg_pkg.
module ccg_datapath import ccg_pkg::*; #(
  parameter int MAX_DEGREE = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ccg_op_t          op_i,
  input  logic             take_i,
  input  logic [DEG_W-1:0] degree_i,
  input  logic             out_free_i,
  output ccg_stat_t        stat_o,
  output ccg_push_t        push_o
);

  localparam int DEPTH = MAX_DEGREE + 1;
  localparam int IDX_W = $clog2(DEPTH);

  logic [COEF_W-1:0] mem_a [DEPTH];
  logic [COEF_W-1:0] mem_b [DEPTH];
  logic [COEF_W-1:0] rd_a_r, rd_b_r;

  logic [IDX_W-1:0]  n_r, k_r, i_r, j_r;
  logic              bad_r, sel_r, obank_r, pend_v_r;
  logic [COEF_W-1:0] pend_coef_r;
  logic [IDX_W-1:0]  pend_pow_r;

  logic [COEF_W-1:0] older_rd, newer_rd, next_coef, scan_val;
  logic              older_ok, newer_ok, row_last;
  logic              scan_nz, scan_push, scan_adv, out_full;
  logic [IDX_W-1:0]  older_addr, newer_addr, addr_a, addr_b;
  logic              we_a, we_b;
  logic [IDX_W-1:0]  wa_a, wa_b;
  logic [COEF_W-1:0] wd_a, wd_b;

  // sel_r low: bank A holds the older row, bank B the newer one.
  assign older_rd = sel_r ? rd_b_r : rd_a_r;
  assign newer_rd = sel_r ? rd_a_r : rd_b_r;
  // Entries above the older row's degree and below index zero read as zero.
  assign older_ok = ({1'b0, i_r} + (IDX_W + 1)'(2)) <= {1'b0, k_r};
  assign newer_ok = (i_r != '0);
  assign next_coef = ((newer_ok ? newer_rd : '0) << 1) - (older_ok ? older_rd : '0);
  assign row_last = (i_r == k_r);

  assign scan_val  = obank_r ? rd_b_r : rd_a_r;
  assign scan_nz   = (scan_val != '0);
  assign out_full  = !out_free_i;
  assign scan_push = scan_nz && pend_v_r;
  assign scan_adv  = !(scan_push && out_full);

  always_comb begin
    older_addr = '0;
    newer_addr = '0;
    unique case (op_i)
      OP_STEP: begin
        older_addr = row_last ? '0 : i_r + IDX_W'(1);
        newer_addr = i_r;
      end
      OP_PRIME_OUT: begin
        older_addr = n_r;
        newer_addr = n_r;
      end
      OP_SCAN: begin
        older_addr = (scan_adv && j_r != '0) ? j_r - IDX_W'(1) : j_r;
        newer_addr = older_addr;
      end
      default: begin
        older_addr = '0;
        newer_addr = '0;
      end
    endcase
  end

  assign addr_a = sel_r ? newer_addr : older_addr;
  assign addr_b = sel_r ? older_addr : newer_addr;

  always_comb begin
    we_a = 1'b0;
    wa_a = '0;
    wd_a = '0;
    we_b = 1'b0;
    wa_b = '0;
    wd_b = '0;
    unique case (op_i)
      OP_INIT_A: begin
        we_a = 1'b1;
        wd_a = COEF_W'(1);
      end
      OP_INIT_B0: begin
        we_b = 1'b1;
      end
      OP_INIT_B1: begin
        we_b = 1'b1;
        wa_b = IDX_W'(1);
        wd_b = COEF_W'(1);
      end
      OP_STEP: begin
        we_a = !sel_r;
        wa_a = i_r;
        wd_a = next_coef;
        we_b = sel_r;
        wa_b = i_r;
        wd_b = next_coef;
      end
      default: begin
        we_a = 1'b0;
        we_b = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[wa_a] <= wd_a;
    end
    rd_a_r <= mem_a[addr_a];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[wa_b] <= wd_b;
    end
    rd_b_r <= mem_b[addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r      <= '0;
      bad_r    <= 1'b0;
      k_r      <= '0;
      i_r      <= '0;
      j_r      <= '0;
      sel_r    <= 1'b0;
      obank_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      unique case (op_i)
        OP_TAKE: begin
          if (take_i) begin
            bad_r <= degree_i > DEG_W'(MAX_DEGREE);
            n_r   <= degree_i[IDX_W-1:0];
          end
        end
        OP_INIT_A: begin
          sel_r <= 1'b0;
          k_r   <= IDX_W'(2);
        end
        OP_PRIME_ROW: i_r <= '0;
        OP_STEP:      i_r <= i_r + IDX_W'(1);
        OP_SWAP: begin
          sel_r <= ~sel_r;
          k_r   <= k_r + IDX_W'(1);
        end
        OP_PRIME_OUT: begin
          j_r      <= n_r;
          obank_r  <= (n_r == '0) ? sel_r : ~sel_r;
          pend_v_r <= 1'b0;
        end
        OP_SCAN: begin
          if (scan_adv) begin
            j_r <= j_r - IDX_W'(1);
            if (scan_nz) begin
              pend_v_r <= 1'b1;
            end
          end
        end
        default: begin
          pend_v_r <= pend_v_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (op_i == OP_SCAN && scan_adv && scan_nz) begin
      pend_coef_r <= scan_val;
      pend_pow_r  <= j_r;
    end
  end

  always_comb begin
    push_o = '{valid: 1'b0, coef: '0, power: '0, last: 1'b0, error: 1'b0};
    unique case (op_i)
      OP_SCAN: begin
        push_o.valid = scan_push && !out_full;
        push_o.coef  = pend_coef_r;
        push_o.power = POW_W'(pend_pow_r);
      end
      OP_FLUSH: begin
        push_o.valid = !out_full;
        push_o.coef  = pend_coef_r;
        push_o.power = POW_W'(pend_pow_r);
        push_o.last  = 1'b1;
      end
      OP_ERR: begin
        push_o.valid = !out_full;
        push_o.last  = 1'b1;
        push_o.error = 1'b1;
      end
      default: begin
        push_o.valid = 1'b0;
      end
    endcase
  end

  assign stat_o = '{
    no_input:  !take_i,
    bad_deg:   bad_r,
    deg_lt2:   (n_r < IDX_W'(2)),
    row_busy:  !row_last,
    more_rows: (k_r != n_r),
    scan_busy: !(scan_adv && j_r == '0),
    out_full:  out_full
  };

endmodule

// ===== src/chebyshev_coefficient_generator_unit.sv =====
`timescale 1ns / 1ps
// Chebyshev coefficient generator top; uses ccg_pkg, ccg_sequencer, ccg_datapath, defines header.
// An out-of-range degree loads only an error result, with no rows built; otherwise the final
// result is loaded once the rows up to the requested degree are built and scanned. An output
// stall can hold any load. One degree is handled at a time; the next is accepted in the
// cycle after the final load.
// Reset (rst_n low, synchronous) returns the sequencer to its wait step and empties the output.
`include "chebyshev_coefficient_generator_unit_defines.svh"

module chebyshev_coefficient_generator_unit import ccg_pkg::*; #(
  parameter int MAX_DEGREE = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [DEG_W-1:0]       in_tdata,   // [7:0] degree
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [63:0] coefficient, [69:64] power, rest zero
  output logic                   out_tlast,
  output logic                   out_tuser   // [0] error
);

  // The control program is a short microcode table in the sequencer. Each
  // step selects one datapath operation and a jump condition. The recurrence
  // c_k[i] = 2*c_{k-1}[i-1] - c_{k-2}[i] runs in place: the row being built
  // overwrites the older row, then the two memories swap roles.

  ccg_ctl_t  ctl;
  ccg_stat_t stat;
  ccg_push_t push;
  logic      take;
  logic      out_free;

  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                   out_tlast_r;
  logic                   out_tuser_r;

  // Only the wait step accepts a transaction, so the degree is latched there.
  assign in_tready = (ctl.op == OP_TAKE);
  assign take      = in_tvalid && in_tready;

  // The output register is a one-deep buffer: new results may be loaded in
  // the same cycle the waiting one is taken.
  assign out_free = !out_tvalid_r || out_tready;

  ccg_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  ccg_datapath #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .op_i       (ctl.op),
    .take_i     (take),
    .degree_i   (in_tdata),
    .out_free_i (out_free),
    .stat_o     (stat),
    .push_o     (push)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (push.valid) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      out_tdata_r <= {(OUT_TDATA_W - POW_W - COEF_W)'(0), push.power, push.coef};
      out_tlast_r <= push.last;
      out_tuser_r <= push.error;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

  // A result is only loaded when the output register has room.
  `CCG_ASSERT_IMPLIES(a_push_room, push.valid, out_free, "result loaded into a full output register")
  // An error result is the last of its run and carries zero payload.
  `CCG_ASSERT_IMPLIES(a_err_zero, out_tvalid_r && out_tuser_r, out_tlast_r && out_tdata_r == '0, "error result with payload")
  // Every normal result carries a nonzero coefficient.
  `CCG_ASSERT_IMPLIES(a_coef_nz, out_tvalid_r && !out_tuser_r, out_tdata_r[COEF_W-1:0] != '0, "zero coefficient emitted")
  // After an input transaction the block is busy with it.
  `CCG_ASSERT_NEXT(a_one_take, take, !in_tready, "second degree accepted while busy")

endmodule
